[hdl/sacache_pkg.sv]
// ----------------------------------------------------------------------------
// sacache_pkg
// Shared types and constants of the set-associative write-back cache tags.
// ----------------------------------------------------------------------------
`default_nettype none

package sacache_pkg;

  // age rank of one line, 0 the most recent
  localparam int unsigned RANK_W   = 3;
  localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;

  // configuration register indices
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK = 2'd2;
  localparam int unsigned CFG_W = 4;

  // access kinds
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // block size limit in address bits
  localparam int unsigned BLOCK_BITS_MAX = 12;

  // lookup outcome
  typedef struct packed {
    logic hit;
    logic evicted;
    logic evicted_dirty;
  } lookup_res_t;

endpackage

`default_nettype wire

[hdl/sacache_mem.sv]
// ----------------------------------------------------------------------------
// sacache_mem
// Set row memory with registered read. Rows never written since
// reset read as zero, tracked by one valid flag per row.
// ----------------------------------------------------------------------------
`default_nettype none

module sacache_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 296,
  parameter int unsigned IDX_W = 8
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              rd_en_i,
  input  wire  [IDX_W-1:0] rd_idx_i,
  output logic [WIDTH-1:0] rd_data_o,
  input  wire              wr_en_i,
  input  wire  [IDX_W-1:0] wr_idx_i,
  input  wire  [WIDTH-1:0] wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] row_vld_q;
  logic [WIDTH-1:0] raw_q;
  logic             raw_vld_q;

  // write and read the array
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      raw_q <= mem[rd_idx_i];
    end
  end

  // track written rows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      raw_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_vld_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        raw_vld_q <= row_vld_q[rd_idx_i];
      end
    end
  end

  assign rd_data_o = raw_vld_q ? raw_q : '0;

endmodule

`default_nettype wire

[hdl/sacache_upd.sv]
// ----------------------------------------------------------------------------
// sacache_upd
// Lookup and update of one set row: hit search, fill way, LRU victim and
// rank ageing.
// ----------------------------------------------------------------------------
`default_nettype none

module sacache_upd
  import sacache_pkg::*;
#(
  parameter int unsigned MAX_WAYS  = 8,
  parameter int unsigned ADDR_BITS = 32,
  parameter int unsigned WCNT_W    = 4
) (
  input  wire  [WCNT_W-1:0]                       ways_i,
  input  wire                                     cmd_i,
  input  wire  [ADDR_BITS-1:0]                    tag_i,
  input  wire  [MAX_WAYS*(ADDR_BITS+RANK_W+2)-1:0] row_i,
  output lookup_res_t                             res_o,
  output logic [ADDR_BITS-1:0]                    vict_tag_o,
  output logic [MAX_WAYS*(ADDR_BITS+RANK_W+2)-1:0] row_o
);

  localparam int unsigned LW    = ADDR_BITS + RANK_W + 2;
  localparam int unsigned DIRTY = ADDR_BITS + RANK_W;
  localparam int unsigned VALID = ADDR_BITS + RANK_W + 1;

  always_comb begin
    logic              hit;
    logic              found;
    int                hw;
    int                iw;
    int                vw;
    int                pick;
    logic [RANK_W-1:0] best;
    logic [RANK_W-1:0] limit;
    logic [LW-1:0]     ln;
    hit   = 1'b0;
    found = 1'b0;
    hw    = 0;
    iw    = 0;
    vw    = 0;
    best  = '0;
    // search hit, first free way and oldest way
    for (int w = 0; w < MAX_WAYS; w++) begin
      ln = row_i[w*LW +: LW];
      if (w < int'(ways_i)) begin
        if (!hit && ln[VALID] && ln[RANK_W +: ADDR_BITS] == tag_i) begin
          hit = 1'b1;
          hw  = w;
        end
        if (!found && !ln[VALID]) begin
          found = 1'b1;
          iw    = w;
        end
        if (ln[RANK_W-1:0] >= best) begin
          best = ln[RANK_W-1:0];
          vw   = w;
        end
      end
    end
    pick  = hit ? hw : (found ? iw : vw);
    ln    = row_i[pick*LW +: LW];
    limit = hit ? ln[RANK_W-1:0] : RANK_MAX;
    res_o.hit           = hit;
    res_o.evicted       = !hit && !found;
    res_o.evicted_dirty = !hit && !found && ln[DIRTY];
    vict_tag_o          = ln[RANK_W +: ADDR_BITS];
    // age the other ways in use, then place the picked line
    row_o = row_i;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (w < int'(ways_i) && w != pick && row_i[w*LW +: RANK_W] < limit) begin
        row_o[w*LW +: RANK_W] = row_i[w*LW +: RANK_W] + RANK_W'(1);
      end
    end
    row_o[pick*LW +: RANK_W] = '0;
    if (hit) begin
      row_o[pick*LW + DIRTY] = ln[DIRTY] | (cmd_i == CMD_WRITE);
    end else begin
      row_o[pick*LW + VALID]          = 1'b1;
      row_o[pick*LW + DIRTY]          = (cmd_i == CMD_WRITE);
      row_o[pick*LW + RANK_W +: ADDR_BITS] = tag_i;
    end
  end

endmodule

`default_nettype wire

[hdl/set_assoc_writeback_lru_cache_tags_top.sv]
// ----------------------------------------------------------------------------
// set_assoc_writeback_lru_cache_tags_top
// Tag and LRU state of a set-associative write-back cache.
//
// An access word (cmd_i, addr_i) enters on in_valid_i while in_stall_o is
// low. One result word per access leaves on out_valid_o and is taken when
// out_stall_i is low: hit, eviction with its block address and dirty bit,
// and the four saturating totals after the access.
// Each access reads the set row from the row memory when it is accepted;
// the lookup state then looks it up and writes the updated row back.
// One access is in flight at a time: the next is not taken until the
// row is written back through the single row memory port pair.
// A finished result waits in the output register; the next access is still
// taken, and its write-back is held while the receiver stalls.
// Configuration words (cfg_index_i, cfg_data_i) are always taken; write
// them only while no access is in flight.
// Reset empties every line at once through per-row valid flags, clears the
// totals and sets one way, one set and 32-byte blocks.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_writeback_lru_cache_tags_top
  import sacache_pkg::*;
#(
  parameter int unsigned MAX_WAYS  = 8,
  parameter int unsigned MAX_SETS  = 256,
  parameter int unsigned ADDR_BITS = 32
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wire                  cmd_i,
  input  wire  [31:0]          addr_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output logic                 hit_o,
  output logic                 evicted_o,
  output logic                 evicted_dirty_o,
  output logic [31:0]          evicted_addr_o,
  output logic [31:0]          hit_total_o,
  output logic [31:0]          miss_total_o,
  output logic [31:0]          dirty_evict_total_o,
  output logic [31:0]          clean_evict_total_o,
  input  wire                  cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire  [CFG_IDX_W-1:0] cfg_index_i,
  input  wire  [CFG_W-1:0]     cfg_data_i
);

  function automatic int floor_log2(input int unsigned v);
    int r;
    r = 0;
    while ((64'd1 << (r + 1)) <= 64'(v)) r++;
    return r;
  endfunction

  localparam int unsigned SET_LOG = floor_log2(MAX_SETS);
  localparam int unsigned IDX_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned WCNT_W  = $clog2(MAX_WAYS + 1);
  localparam int unsigned LW      = ADDR_BITS + RANK_W + 2;
  localparam int unsigned ROW_W   = MAX_WAYS * LW;
  localparam int unsigned SH_W    = $clog2(ADDR_BITS + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOOK = 1'b1;

  logic                 state_q, state_d;
  logic [CFG_W-1:0]     cfg_ways_q, cfg_sets_q, cfg_block_q;
  logic                 cmd_q;
  logic [ADDR_BITS-1:0] tag_q;
  logic [IDX_W-1:0]     set_q;
  logic [SH_W-1:0]      b_q, sb_q;
  logic [WCNT_W-1:0]    ways_q;
  logic [31:0]          hit_tot_q, miss_tot_q, dev_tot_q, cev_tot_q;
  logic                 out_vld_q;
  lookup_res_t          res_q;
  logic [31:0]          ev_addr_q;

  logic                 accept, done;
  logic [ADDR_BITS-1:0] a_ext, tag_d, vict_tag, ev_addr;
  logic [IDX_W-1:0]     set_d;
  logic [SH_W-1:0]      b_d, sb_d;
  logic [WCNT_W-1:0]    ways_d;
  logic [ROW_W-1:0]     row_rd, row_wr;
  lookup_res_t          res;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign done        = (state_q == ST_LOOK) && (!out_vld_q || !out_stall_i);
  assign cfg_ready_o = 1'b1;

  // split the address under the clamped geometry
  always_comb begin
    int b;
    int s;
    int wy;
    logic [ADDR_BITS-1:0] msk;
    b  = (int'(cfg_block_q) > BLOCK_BITS_MAX) ? BLOCK_BITS_MAX : int'(cfg_block_q);
    s  = (int'(cfg_sets_q) > SET_LOG) ? SET_LOG : int'(cfg_sets_q);
    if (s + b >= ADDR_BITS) s = ADDR_BITS - 1 - b;
    if (s < 0) s = 0;
    wy = (cfg_ways_q == '0) ? 1 :
         ((int'(cfg_ways_q) > MAX_WAYS) ? MAX_WAYS : int'(cfg_ways_q));
    a_ext  = ADDR_BITS'(addr_i);
    msk    = (ADDR_BITS'(1) << s) - ADDR_BITS'(1);
    set_d  = IDX_W'((a_ext >> b) & msk);
    tag_d  = a_ext >> (s + b);
    b_d    = SH_W'(b);
    sb_d   = SH_W'(s + b);
    ways_d = WCNT_W'(wy);
  end

  sacache_mem #(
    .DEPTH (MAX_SETS),
    .WIDTH (ROW_W),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_idx_i  (set_d),
    .rd_data_o (row_rd),
    .wr_en_i   (done),
    .wr_idx_i  (set_q),
    .wr_data_i (row_wr)
  );

  sacache_upd #(
    .MAX_WAYS  (MAX_WAYS),
    .ADDR_BITS (ADDR_BITS),
    .WCNT_W    (WCNT_W)
  ) u_upd (
    .ways_i     (ways_q),
    .cmd_i      (cmd_q),
    .tag_i      (tag_q),
    .row_i      (row_rd),
    .res_o      (res),
    .vict_tag_o (vict_tag),
    .row_o      (row_wr)
  );

  // rebuild the block address of the victim
  assign ev_addr = res.evicted ?
                   ((vict_tag << sb_q) | (ADDR_BITS'(set_q) << b_q)) : '0;

  // sequence one access
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_LOOK;
      ST_LOOK: if (done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // hold the access fields
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_i;
      tag_q  <= tag_d;
      set_q  <= set_d;
      b_q    <= b_d;
      sb_q   <= sb_d;
      ways_q <= ways_d;
    end
    if (done) begin
      res_q     <= res;
      ev_addr_q <= 32'(ev_addr);
    end
  end

  // control, configuration and totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_ways_q  <= 4'd1;
      cfg_sets_q  <= 4'd0;
      cfg_block_q <= 4'd5;
      out_vld_q   <= 1'b0;
      hit_tot_q   <= '0;
      miss_tot_q  <= '0;
      dev_tot_q   <= '0;
      cev_tot_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_WAYS:  cfg_ways_q  <= cfg_data_i;
          CFG_SETS:  cfg_sets_q  <= cfg_data_i;
          CFG_BLOCK: cfg_block_q <= cfg_data_i;
          default:   ;
        endcase
      end
      if (done) begin
        out_vld_q <= 1'b1;
        if (res.hit && hit_tot_q != '1) hit_tot_q <= hit_tot_q + 32'd1;
        if (!res.hit && miss_tot_q != '1) miss_tot_q <= miss_tot_q + 32'd1;
        if (res.evicted && res.evicted_dirty && dev_tot_q != '1) begin
          dev_tot_q <= dev_tot_q + 32'd1;
        end
        if (res.evicted && !res.evicted_dirty && cev_tot_q != '1) begin
          cev_tot_q <= cev_tot_q + 32'd1;
        end
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o         = out_vld_q;
  assign hit_o               = res_q.hit;
  assign evicted_o           = res_q.evicted;
  assign evicted_dirty_o     = res_q.evicted_dirty;
  assign evicted_addr_o      = ev_addr_q;
  assign hit_total_o         = hit_tot_q;
  assign miss_total_o        = miss_tot_q;
  assign dirty_evict_total_o = dev_tot_q;
  assign clean_evict_total_o = cev_tot_q;

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && evicted_o))
    else $error("hit reported with eviction");

  // a dirty victim is a victim
  a_dirty_is_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && evicted_dirty_o |-> evicted_o)
    else $error("dirty flag without eviction");

  // an accepted word blocks the input during its lookup
  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input open during lookup");

  // totals move only on a finished lookup
  a_totals_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done |=> $stable(hit_tot_q) && $stable(miss_tot_q))
    else $error("totals moved without a lookup");

endmodule

`default_nettype wire
